// File: hw/rtl/fsp_pkg.sv
// Package for the fair share thread picker: sizes, operation and status codes,
// and the command and status structs shared by the controller and the datapath.
// No dependencies.
package fsp_pkg;

  localparam int SLOT_COUNT  = 16;
  localparam int TID_W       = 4;
  localparam int CNT_W       = 5;
  localparam int VT_W        = 64;
  localparam int STAMP_W     = 32;
  localparam int FUNC_W      = 2;
  localparam int STATUS_W    = 3;

  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_YIELD  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_SLEEP  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NONE    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ALREADY = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTRUN  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD     = 3'd4;

  typedef struct packed {
    logic                latch;
    logic                rd_run;
    logic                rd_scan;
    logic [TID_W-1:0]    scan_idx;
    logic                scan_clr;
    logic                charge_wr;
    logic                charge_mark;
    logic                add_do;
    logic                rem_do;
    logic                take;
    logic                take_dec;
    logic                out_load;
    logic [STATUS_W-1:0] out_status;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              tid_bad;
    logic              tid_runnable;
    logic              found;
  } sts_t;

endpackage

// File: hw/rtl/fsp_if.sv
// Channel interfaces for the fair share thread picker: request words in,
// result words out, each with valid and ready. Depends on fsp_pkg.
interface fsp_in_if;
  logic                          valid;
  logic                          ready;
  logic [fsp_pkg::FUNC_W-1:0]    func;
  logic [fsp_pkg::TID_W-1:0]     thread_id;
  logic [fsp_pkg::VT_W-1:0]      now_us;

  modport source (output valid, output func, output thread_id, output now_us, input ready);
  modport sink   (input valid, input func, input thread_id, input now_us, output ready);
endinterface

interface fsp_out_if;
  logic                          valid;
  logic                          ready;
  logic [fsp_pkg::TID_W-1:0]     next_thread;
  logic                          switch_needed;
  logic [fsp_pkg::STATUS_W-1:0]  status;
  logic [fsp_pkg::CNT_W-1:0]     thread_count;
  logic [fsp_pkg::VT_W-1:0]      picked_vruntime;

  modport source (output valid, output next_thread, output switch_needed, output status,
                  output thread_count, output picked_vruntime, input ready);
  modport sink   (input valid, input next_thread, input switch_needed, input status,
                  input thread_count, input picked_vruntime, output ready);
endinterface

// File: hw/rtl/fair_share_thread_picker_top.sv
// Fair share thread picker: one request word in, one result word out.
// Request: func (add, remove, yield and pick, sleep and pick), thread_id, now_us.
// Result: next_thread, switch_needed, status, thread_count, picked_vruntime.
// Both channels use valid/ready; a word moves when both are high.
// Add and remove finish without a scan; yield and sleep also pick, and sleep
// skips the charge when it finds nothing runnable. The pick reads the vruntime
// and stamp memories one slot a cycle over all 16 slots, and the running thread
// is charged by a read through the scan's read port and a write back. The next
// request can be accepted at the edge at which the result can first be taken.
// One request is in work at a time; in_ready is high only between requests.
// A result waits in the output register while the next request is accepted;
// if the receiver stalls, that request finishes up to its result and holds
// until the register frees.
// Reset (rst_n low, synchronous) empties both channels and sets thread 0
// running, nothing runnable, all vruntimes, stamps and times zero.
// Depends on fsp_pkg, fsp_if, fsp_ctrl and fsp_dp.
module fair_share_thread_picker_top (
  input  logic       clk,
  input  logic       rst_n,
  fsp_in_if.sink     in_ch,
  fsp_out_if.source  out_ch
);

  fsp_pkg::cmd_t cmd;
  fsp_pkg::sts_t sts;
  logic          in_ready;
  logic          out_valid;

  fsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fsp_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_func             (in_ch.func),
    .in_tid              (in_ch.thread_id),
    .in_now              (in_ch.now_us),
    .out_next_thread     (out_ch.next_thread),
    .out_switch_needed   (out_ch.switch_needed),
    .out_status          (out_ch.status),
    .out_thread_count    (out_ch.thread_count),
    .out_picked_vruntime (out_ch.picked_vruntime)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule

// File: hw/rtl/fsp_dp.sv
// Datapath of the fair share thread picker: vruntime and stamp memories,
// runnable marks, scheduler registers, minimum scan and result register.
// Depends on fsp_pkg; driven by fsp_ctrl through fsp_pkg::cmd_t.
module fsp_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  fsp_pkg::cmd_t                  cmd,
  output fsp_pkg::sts_t                  sts,
  input  logic [fsp_pkg::FUNC_W-1:0]     in_func,
  input  logic [fsp_pkg::TID_W-1:0]      in_tid,
  input  logic [fsp_pkg::VT_W-1:0]       in_now,
  output logic [fsp_pkg::TID_W-1:0]      out_next_thread,
  output logic                           out_switch_needed,
  output logic [fsp_pkg::STATUS_W-1:0]   out_status,
  output logic [fsp_pkg::CNT_W-1:0]      out_thread_count,
  output logic [fsp_pkg::VT_W-1:0]       out_picked_vruntime
);

  logic [fsp_pkg::VT_W-1:0]        vt_mem [fsp_pkg::SLOT_COUNT];
  logic [fsp_pkg::STAMP_W-1:0]     st_mem [fsp_pkg::SLOT_COUNT];
  logic [fsp_pkg::SLOT_COUNT-1:0]  mem_ok_r;
  logic [fsp_pkg::SLOT_COUNT-1:0]  runnable_r;

  logic [fsp_pkg::FUNC_W-1:0]  func_r;
  logic [fsp_pkg::TID_W-1:0]   tid_r;
  logic [fsp_pkg::VT_W-1:0]    now_r;
  logic [fsp_pkg::VT_W-1:0]    delta_r;
  logic [fsp_pkg::TID_W-1:0]   prev_run_r;

  logic [fsp_pkg::TID_W-1:0]   running_r;
  logic [fsp_pkg::VT_W-1:0]    min_r;
  logic [fsp_pkg::VT_W-1:0]    start_r;
  logic [fsp_pkg::CNT_W-1:0]   live_r;
  logic [fsp_pkg::STAMP_W-1:0] stamp_cnt_r;

  logic [fsp_pkg::VT_W-1:0]    rd_vt_r;
  logic [fsp_pkg::STAMP_W-1:0] rd_st_r;
  logic                        rd_ok_r;
  logic                        cmp_vld_r;
  logic [fsp_pkg::TID_W-1:0]   cmp_idx_r;

  logic                        found_r;
  logic [fsp_pkg::TID_W-1:0]   best_idx_r;
  logic [fsp_pkg::VT_W-1:0]    best_vt_r;
  logic [fsp_pkg::STAMP_W-1:0] best_st_r;

  logic [fsp_pkg::TID_W-1:0]    out_next_r;
  logic                         out_sw_r;
  logic [fsp_pkg::STATUS_W-1:0] out_status_r;
  logic [fsp_pkg::CNT_W-1:0]    out_count_r;
  logic [fsp_pkg::VT_W-1:0]     out_vt_r;

  logic [fsp_pkg::VT_W-1:0]    rd_vt_eff;
  logic [fsp_pkg::STAMP_W-1:0] rd_st_eff;
  logic                        rd_en;
  logic [fsp_pkg::TID_W-1:0]   raddr;
  logic                        wr_en;
  logic [fsp_pkg::TID_W-1:0]   waddr;
  logic [fsp_pkg::VT_W-1:0]    wvt;
  logic [fsp_pkg::STAMP_W-1:0] wst;
  logic                        better;

  assign rd_vt_eff = rd_ok_r ? rd_vt_r : '0;
  assign rd_st_eff = rd_ok_r ? rd_st_r : '0;

  assign rd_en = cmd.rd_run | cmd.rd_scan;
  assign raddr = cmd.rd_run ? running_r : cmd.scan_idx;
  assign wr_en = cmd.charge_wr | cmd.add_do;
  assign waddr = cmd.add_do ? tid_r : running_r;
  assign wvt   = cmd.add_do ? min_r : rd_vt_eff + delta_r;
  assign wst   = (cmd.add_do | cmd.charge_mark) ? stamp_cnt_r : rd_st_eff;

  assign better = cmp_vld_r && runnable_r[cmp_idx_r] &&
                  (!found_r || (rd_vt_eff < best_vt_r) ||
                   ((rd_vt_eff == best_vt_r) && (rd_st_eff < best_st_r)));

  assign sts.func         = func_r;
  assign sts.tid_bad      = ({1'b0, tid_r} >= fsp_pkg::CNT_W'(fsp_pkg::SLOT_COUNT)) ||
                            (tid_r == running_r);
  assign sts.tid_runnable = runnable_r[tid_r];
  assign sts.found        = found_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      vt_mem[waddr] <= wvt;
      st_mem[waddr] <= wst;
    end
    if (rd_en) begin
      rd_vt_r <= vt_mem[raddr];
      rd_st_r <= st_mem[raddr];
      rd_ok_r <= mem_ok_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r     <= in_func;
      tid_r      <= in_tid;
      now_r      <= in_now;
      delta_r    <= in_now - start_r;
      prev_run_r <= running_r;
    end
    cmp_idx_r <= cmd.scan_idx;
    if (better) begin
      best_idx_r <= cmp_idx_r;
      best_vt_r  <= rd_vt_eff;
      best_st_r  <= rd_st_eff;
    end
    if (cmd.out_load) begin
      out_next_r   <= running_r;
      out_sw_r     <= (running_r != prev_run_r);
      out_status_r <= cmd.out_status;
      out_count_r  <= live_r;
      out_vt_r     <= min_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_ok_r    <= '0;
      runnable_r  <= '0;
      running_r   <= '0;
      min_r       <= '0;
      start_r     <= '0;
      live_r      <= fsp_pkg::CNT_W'(1);
      stamp_cnt_r <= '0;
      cmp_vld_r   <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.rd_scan;
      if (wr_en) begin
        mem_ok_r[waddr] <= 1'b1;
      end
      if (cmd.scan_clr) begin
        found_r <= 1'b0;
      end else if (better) begin
        found_r <= 1'b1;
      end
      if (cmd.add_do) begin
        runnable_r[tid_r] <= 1'b1;
        live_r            <= live_r + fsp_pkg::CNT_W'(1);
        stamp_cnt_r       <= stamp_cnt_r + fsp_pkg::STAMP_W'(1);
      end
      if (cmd.rem_do) begin
        runnable_r[tid_r] <= 1'b0;
        live_r            <= live_r - fsp_pkg::CNT_W'(1);
      end
      if (cmd.charge_wr && cmd.charge_mark) begin
        runnable_r[running_r] <= 1'b1;
        stamp_cnt_r           <= stamp_cnt_r + fsp_pkg::STAMP_W'(1);
      end
      if (cmd.take) begin
        runnable_r[best_idx_r] <= 1'b0;
        running_r              <= best_idx_r;
        min_r                  <= best_vt_r;
        start_r                <= now_r;
        if (cmd.take_dec) begin
          live_r <= live_r - fsp_pkg::CNT_W'(1);
        end
      end
    end
  end

  assign out_next_thread     = out_next_r;
  assign out_switch_needed   = out_sw_r;
  assign out_status          = out_status_r;
  assign out_thread_count    = out_count_r;
  assign out_picked_vruntime = out_vt_r;

`ifndef SYNTH
  a_take_found: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |-> found_r)
    else $error("take without a runnable winner");
  a_take_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> !runnable_r[running_r])
    else $error("running thread still marked runnable");
  a_live_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (32'(live_r) == $countones(runnable_r) + 1))
    else $error("live count out of step with runnable marks");
`endif

endmodule

// File: hw/rtl/fsp_ctrl.sv
// Controller of the fair share thread picker: sequences add, remove, charge,
// minimum scan, take and result hand-off. Depends on fsp_pkg; drives fsp_dp.
module fsp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  fsp_pkg::sts_t sts,
  output fsp_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_CHARGE   = 4'd2;
  localparam logic [3:0] S_SCAN     = 4'd3;
  localparam logic [3:0] S_SCAN_END = 4'd4;
  localparam logic [3:0] S_POST     = 4'd5;
  localparam logic [3:0] S_TAKE     = 4'd6;
  localparam logic [3:0] S_DONE     = 4'd7;

  logic [3:0]                     state_r, state_nxt;
  logic [fsp_pkg::TID_W-1:0]      cnt_r, cnt_nxt;
  logic [fsp_pkg::STATUS_W-1:0]   status_r, status_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           is_yield;

  assign is_yield  = (sts.func == fsp_pkg::FUNC_YIELD);
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    cmd            = '0;
    cmd.scan_idx   = cnt_r;
    cmd.out_status = status_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.func)
          fsp_pkg::FUNC_ADD: begin
            if (sts.tid_bad) begin
              status_nxt = fsp_pkg::ST_BAD;
            end else if (sts.tid_runnable) begin
              status_nxt = fsp_pkg::ST_ALREADY;
            end else begin
              status_nxt = fsp_pkg::ST_OK;
              cmd.add_do = 1'b1;
            end
            state_nxt = S_DONE;
          end
          fsp_pkg::FUNC_REMOVE: begin
            if (sts.tid_bad) begin
              status_nxt = fsp_pkg::ST_BAD;
            end else if (!sts.tid_runnable) begin
              status_nxt = fsp_pkg::ST_NOTRUN;
            end else begin
              status_nxt = fsp_pkg::ST_OK;
              cmd.rem_do = 1'b1;
            end
            state_nxt = S_DONE;
          end
          fsp_pkg::FUNC_YIELD: begin
            status_nxt = fsp_pkg::ST_OK;
            cmd.rd_run = 1'b1;
            state_nxt  = S_CHARGE;
          end
          default: begin
            status_nxt = fsp_pkg::ST_OK;
            cnt_nxt    = '0;
            state_nxt  = S_SCAN;
          end
        endcase
      end
      S_CHARGE: begin
        cmd.charge_wr   = 1'b1;
        cmd.charge_mark = is_yield;
        if (is_yield) begin
          cnt_nxt   = '0;
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_TAKE;
        end
      end
      S_SCAN: begin
        cmd.rd_scan  = 1'b1;
        cmd.scan_clr = (cnt_r == '0);
        cnt_nxt      = cnt_r + fsp_pkg::TID_W'(1);
        if (cnt_r == fsp_pkg::TID_W'(fsp_pkg::SLOT_COUNT - 1)) begin
          state_nxt = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        state_nxt = S_POST;
      end
      S_POST: begin
        if (is_yield) begin
          state_nxt = S_TAKE;
        end else if (!sts.found) begin
          status_nxt = fsp_pkg::ST_NONE;
          state_nxt  = S_DONE;
        end else begin
          cmd.rd_run = 1'b1;
          state_nxt  = S_CHARGE;
        end
      end
      S_TAKE: begin
        cmd.take     = 1'b1;
        cmd.take_dec = !is_yield;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      status_r    <= fsp_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result word overwritten before it was taken");
  a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && !out_valid_r |=> out_valid_r && (state_r == S_IDLE))
    else $error("finished operation did not present its result");
`endif

endmodule
